@@ hdl/periodic_timer_bank_assert.svh @@
// Assertion macros used by the timer bank port checker.
`ifndef PERIODIC_TIMER_BANK_ASSERT_SVH
`define PERIODIC_TIMER_BANK_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTB_ASSERT_NOW(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
		else $error("timer bank assertion failed");

// Consequent checked in the cycle after the antecedent.
`define PTB_ASSERT_NEXT(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
		else $error("timer bank assertion failed");

`endif

@@ hdl/ptb_pkg.sv @@
// Package of the periodic timer bank: sizes, command codes and shared types.
`default_nettype none
package ptb_pkg;

	localparam int TIMER_CHANNELS = 8;
	localparam int CH_W = (TIMER_CHANNELS > 1) ? $clog2(TIMER_CHANNELS) : 1;
	localparam int CNT_W = $clog2(TIMER_CHANNELS + 1);

	localparam int KIND_W = 3;
	localparam int CHAN_W = 3;
	localparam int DATA_W = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		K_TICK     = 3'd0,
		K_POLL     = 3'd1,
		K_ADD      = 3'd2,
		K_REMOVE   = 3'd3,
		K_ENABLE   = 3'd4,
		K_INTERVAL = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t             op;
		logic [CH_W-1:0]   ch;
		logic [DATA_W-1:0] value;  // tick amount or interval
		logic              en;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

@@ hdl/ptb_ifs.sv @@
// Command and event channel interfaces of the timer bank.
`default_nettype none
interface ptb_cmd_if;
	import ptb_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CHAN_W-1:0] channel;
	logic [DATA_W-1:0] tick_amount;
	logic [DATA_W-1:0] interval_value;
	logic              enable_value;

	modport source (output valid, kind, channel, tick_amount, interval_value,
		enable_value, input ready);
	modport sink (input valid, kind, channel, tick_amount, interval_value,
		enable_value, output ready);
endinterface

interface ptb_evt_if;
	import ptb_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] fired_channel;
	logic              fired;
	logic              last;

	modport source (output valid, fired_channel, fired, last, input ready);
	modport sink (input valid, fired_channel, fired, last, output ready);
endinterface
`default_nettype wire

@@ hdl/ptb_queue.sv @@
// Short command queue between the front and back of the timer bank.
`default_nettype none
module ptb_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ptb_pkg::cmd_t    push_word,
	input  logic             pop,
	output ptb_pkg::cmd_t    head,
	output ptb_pkg::q_stat_t stat
);
	import ptb_pkg::*;

	cmd_t            mem_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (cnt_q == QC_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QC_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QC_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/ptb_front.sv @@
// Front end: takes command words, drops no-ops, packs the rest for the queue.
`default_nettype none
module ptb_front (
	ptb_cmd_if.sink          cmd,
	input  ptb_pkg::q_stat_t q_stat,
	output logic             push,
	output ptb_pkg::cmd_t    push_word
);
	import ptb_pkg::*;

	logic ch_ok;
	logic keep;

	assign ch_ok     = int'(cmd.channel) < TIMER_CHANNELS;
	assign cmd.ready = !q_stat.full;

	always_comb begin
		case (cmd.kind)
			K_TICK, K_POLL: keep = 1'b1;
			K_ADD, K_REMOVE, K_ENABLE, K_INTERVAL: keep = ch_ok;
			default: keep = 1'b0;
		endcase
	end

	assign push            = cmd.valid && cmd.ready && keep;
	assign push_word.op    = kind_t'(cmd.kind);
	assign push_word.ch    = CH_W'(cmd.channel);
	assign push_word.value = (cmd.kind == K_TICK) ? cmd.tick_amount : cmd.interval_value;
	assign push_word.en    = cmd.enable_value;

endmodule
`default_nettype wire

@@ hdl/ptb_back.sv @@
// Back end: channel tables, uptime, poll walker and event output register.
`default_nettype none
module ptb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ptb_pkg::cmd_t    head,
	input  ptb_pkg::q_stat_t q_stat,
	output logic             pop,
	ptb_evt_if.source        evt
);
	import ptb_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_POLL
	} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] uptime_q;
	logic [DATA_W-1:0] stamp_q  [TIMER_CHANNELS];
	logic [DATA_W-1:0] period_q [TIMER_CHANNELS];
	logic              en_q     [TIMER_CHANNELS];
	logic              present_q[TIMER_CHANNELS];
	logic [CH_W-1:0]   order_q  [TIMER_CHANNELS];
	logic [CNT_W-1:0]  count_q;

	logic [CNT_W-1:0]  idx_q;
	logic              pend_q;
	logic [CH_W-1:0]   pend_ch_q;
	logic              out_valid_q;
	logic [CHAN_W-1:0] out_ch_q;
	logic              out_fired_q;
	logic              out_last_q;

	logic              bank_full;
	logic              hd_present;
	logic              add_new;
	logic              do_remove;
	logic [TIMER_CHANNELS-1:0] shift;
	logic              walking;
	logic [CH_W-1:0]   pch;
	logic [DATA_W-1:0] elapsed;
	logic              hit;
	logic              can_emit;
	logic              step_go;
	logic              restamp;

	assign pop        = (state_q == ST_IDLE) && !q_stat.empty;
	assign bank_full  = (count_q == CNT_W'(TIMER_CHANNELS));
	assign hd_present = present_q[head.ch];
	assign add_new    = pop && (head.op == K_ADD) && !hd_present && !bank_full;
	assign do_remove  = pop && (head.op == K_REMOVE) && hd_present;

	// Entries at and after the removed channel's slot move down by one.
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int j = 0; j < TIMER_CHANNELS; j++) begin
			seen     = seen || ((CNT_W'(j) < count_q) && (order_q[j] == head.ch));
			shift[j] = seen;
		end
	end

	assign walking  = idx_q < count_q;
	assign pch      = order_q[idx_q[CH_W-1:0]];
	assign elapsed  = uptime_q - stamp_q[pch];
	assign hit      = walking && en_q[pch] && (elapsed >= period_q[pch]);
	assign can_emit = !out_valid_q || evt.ready;
	assign step_go  = (state_q == ST_POLL) && walking && !(hit && pend_q && !can_emit);
	assign restamp  = step_go && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uptime_q <= '0;
			count_q  <= '0;
			for (int j = 0; j < TIMER_CHANNELS; j++) begin
				stamp_q[j]   <= '0;
				period_q[j]  <= '0;
				en_q[j]      <= 1'b0;
				present_q[j] <= 1'b0;
			end
		end else begin
			if (restamp) begin
				stamp_q[pch] <= uptime_q;
			end
			if (pop) begin
				case (head.op)
					K_TICK: uptime_q <= uptime_q + head.value;
					K_ADD: begin
						if (hd_present || !bank_full) begin
							period_q[head.ch] <= head.value;
							en_q[head.ch]     <= head.en;
							stamp_q[head.ch]  <= '0;
						end
						if (add_new) begin
							present_q[head.ch] <= 1'b1;
							count_q            <= count_q + CNT_W'(1);
						end
					end
					K_REMOVE: begin
						if (hd_present) begin
							present_q[head.ch] <= 1'b0;
							count_q            <= count_q - CNT_W'(1);
						end
					end
					K_ENABLE: begin
						if (hd_present) begin
							en_q[head.ch] <= head.en;
						end
					end
					K_INTERVAL: begin
						if (hd_present) begin
							period_q[head.ch] <= head.value;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_new) begin
			order_q[count_q[CH_W-1:0]] <= head.ch;
		end
		if (do_remove) begin
			for (int j = 0; j < TIMER_CHANNELS - 1; j++) begin
				if (shift[j]) begin
					order_q[j] <= order_q[j + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			pend_ch_q   <= '0;
			out_valid_q <= 1'b0;
			out_ch_q    <= '0;
			out_fired_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && head.op == K_POLL) begin
						state_q <= ST_POLL;
						idx_q   <= '0;
						pend_q  <= 1'b0;
					end
				end
				ST_POLL: begin
					if (walking) begin
						if (step_go) begin
							idx_q <= idx_q + CNT_W'(1);
							if (hit) begin
								pend_q    <= 1'b1;
								pend_ch_q <= pch;
								if (pend_q) begin
									out_valid_q <= 1'b1;
									out_ch_q    <= CHAN_W'(pend_ch_q);
									out_fired_q <= 1'b1;
									out_last_q  <= 1'b0;
								end
							end
						end
					end else if (can_emit) begin
						out_valid_q <= 1'b1;
						out_ch_q    <= pend_q ? CHAN_W'(pend_ch_q) : '0;
						out_fired_q <= pend_q;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign evt.valid         = out_valid_q;
	assign evt.fired_channel = out_ch_q;
	assign evt.fired         = out_fired_q;
	assign evt.last          = out_last_q;

endmodule
`default_nettype wire

@@ hdl/periodic_timer_bank.sv @@
// Top level of the periodic timer bank: front end, command queue, back end.
//
//   port | dir | words carried
//   -----+-----+---------------------------------------------------------
//   cmd  | in  | kind, channel, tick_amount, interval_value, enable_value
//   evt  | out | fired_channel, fired, last (poll results only)
//
// Tick, add, remove, enable and interval words are applied as the back end pops them.
// A poll walks the present channels in order, one channel a cycle while not stalled.
// Words queue two deep behind the back end; cmd.ready drops when it is full.
// A held event on evt stalls a poll only when a further event is due.
// Reset clears uptime, the stamp, period, enable and presence tables and the queue at once.
`default_nettype none
module periodic_timer_bank (
	input  logic      clk,
	input  logic      arst_n,
	ptb_cmd_if.sink   cmd,
	ptb_evt_if.source evt
);
	import ptb_pkg::*;

	q_stat_t q_stat;
	cmd_t    push_word;
	cmd_t    head;
	logic    push;
	logic    pop;

	ptb_front u_front (
		.cmd       (cmd),
		.q_stat    (q_stat),
		.push      (push),
		.push_word (push_word)
	);

	ptb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	ptb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.evt    (evt)
	);

endmodule
`default_nettype wire

@@ hdl/ptb_checker.sv @@
// Port-level checker for the timer bank and its bind to the top level.
`default_nettype none
`include "periodic_timer_bank_assert.svh"
module ptb_port_props (
	input logic       clk,
	input logic       arst_n,
	input logic       evt_valid,
	input logic       evt_ready,
	input logic [2:0] fired_channel,
	input logic       fired,
	input logic       last
);

	logic [4:0] evt_word;

	assign evt_word = {fired_channel, fired, last};

	`PTB_ASSERT_NEXT(a_evt_hold, clk, arst_n, evt_valid && !evt_ready, evt_valid)
	`PTB_ASSERT_NEXT(a_evt_stable, clk, arst_n, evt_valid && !evt_ready, $stable(evt_word))
	`PTB_ASSERT_NOW(a_empty_is_last, clk, arst_n, evt_valid && !fired, last)
	`PTB_ASSERT_NOW(a_empty_ch_zero, clk, arst_n, evt_valid && !fired, fired_channel == 3'd0)

endmodule

bind periodic_timer_bank ptb_port_props u_ptb_port_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.evt_valid     (evt.valid),
	.evt_ready     (evt.ready),
	.fired_channel (evt.fired_channel),
	.fired         (evt.fired),
	.last          (evt.last)
);
`default_nettype wire
